// File: rtl/core/hpap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpap_pkg
// Types and constants shared by the PORT argument parser modules.
// ----------------------------------------------------------------------------
package hpap_pkg;

   // Byte values that the parser recognises.
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] CHAR_TAB        = 8'd9;
   localparam logic [7:0] CHAR_CR         = 8'd13;
   localparam logic [7:0] CHAR_SPACE      = 8'd32;
   localparam logic [7:0] CHAR_PLUS       = 8'd43;
   localparam logic [7:0] CHAR_MINUS      = 8'd45;
   localparam logic [7:0] CHAR_ZERO       = 8'd48;
   localparam logic [7:0] CHAR_NINE       = 8'd57;

   // Number limits.
   localparam logic [2:0]  NUMBER_TOTAL    = 3'd6;
   localparam logic [2:0]  ADDRESS_NUMBERS = 3'd4;
   localparam logic [8:0]  MAX_BYTE_VALUE  = 9'd255;
   localparam logic [8:0]  SATURATE_VALUE  = 9'h100;
   localparam logic [11:0] RADIX           = 12'd10;

   typedef enum logic [2:0] {
      PH_BETWEEN  = 3'd0,
      PH_LEAD     = 3'd1,
      PH_SIGN     = 3'd2,
      PH_DIGITS   = 3'd3,
      PH_TAIL_OK  = 3'd4,
      PH_TAIL_BAD = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FEW     = 2'd1,
      ST_NODIGIT = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] arg_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] address;
      logic [15:0] port_number;
   } rsp_payload_type;

endpackage

// File: rtl/core/hpap_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpap_in_reg
// Input register holding one argument byte until the parser takes it.
// ----------------------------------------------------------------------------
module hpap_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hpap_pkg::req_payload_type req_payload,
   input  logic                     advance,
   output logic                     hold_valid,
   output hpap_pkg::req_payload_type hold_data
);
   import hpap_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;
   req_payload_type data_in;
   logic            take;

   // The slot may be refilled in the same cycle that the parser empties it.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

// File: rtl/core/hpap_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpap_parser
// Token state, accumulators and the per-byte update of the PORT argument.
// ----------------------------------------------------------------------------
module hpap_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_write_data,
   input  logic                      byte_valid,
   input  hpap_pkg::req_payload_type byte_data,
   input  logic                      result_ready,
   output logic                      byte_taken,
   output logic                      result_valid,
   output hpap_pkg::rsp_payload_type result_data
);
   import hpap_pkg::*;

   logic [7:0]  delimiter_ff;
   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [8:0]  value_ff, value_in;
   logic        minus_ff, minus_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;
   status_type  error_ff, error_in;

   logic        is_delim, is_digit, is_blank, last;
   logic [3:0]  digit_value;
   logic [11:0] scaled_value;

   phase_type   step_phase;
   logic [8:0]  step_value;
   logic        step_minus;

   phase_type   close_phase;
   logic [8:0]  close_value;
   logic        close_minus;
   logic [2:0]  closed_count;
   logic [31:0] closed_addr;
   logic [15:0] closed_port;
   status_type  closed_error;
   status_type  final_status;

   assign last        = byte_data.last_byte;
   assign is_delim    = byte_data.arg_byte == delimiter_ff;
   assign is_digit    = byte_data.arg_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_blank    = byte_data.arg_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   assign digit_value = byte_data.arg_byte[3:0];

   // A final byte needs room in the result register; other bytes never wait.
   assign byte_taken  = byte_valid && (!last || result_ready);

   assign scaled_value = 12'(value_ff) * RADIX + 12'(digit_value);

   // Effect of one non-delimiter byte on the open token.
   always_comb begin
      step_phase = (phase_ff == PH_BETWEEN) ? PH_LEAD : phase_ff;
      step_value = value_ff;
      step_minus = minus_ff;
      case (step_phase)
         PH_LEAD: begin
            if (is_blank) begin
               step_phase = PH_LEAD;
            end else if (byte_data.arg_byte == CHAR_PLUS) begin
               step_phase = PH_SIGN;
            end else if (byte_data.arg_byte == CHAR_MINUS) begin
               step_phase = PH_SIGN;
               step_minus = 1'b1;
            end else if (is_digit) begin
               step_phase = PH_DIGITS;
               step_value = 9'(digit_value);
            end else begin
               step_phase = PH_TAIL_BAD;
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               step_phase = PH_DIGITS;
               step_value = 9'(digit_value);
            end else begin
               step_phase = PH_TAIL_BAD;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               step_value = (scaled_value > 12'(SATURATE_VALUE)) ?
                            SATURATE_VALUE : scaled_value[8:0];
            end else begin
               step_phase = PH_TAIL_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // Closing a token: a delimiter closes the token as it stood, a final byte
   // closes it after the byte has been applied.
   always_comb begin
      close_phase  = is_delim ? phase_ff : step_phase;
      close_value  = is_delim ? value_ff : step_value;
      close_minus  = is_delim ? minus_ff : step_minus;
      closed_count = count_ff;
      closed_addr  = addr_ff;
      closed_port  = port_ff;
      closed_error = error_ff;
      if (close_phase != PH_BETWEEN && count_ff < NUMBER_TOTAL && error_ff == ST_OK) begin
         if (close_phase != PH_DIGITS && close_phase != PH_TAIL_OK) begin
            closed_error = ST_NODIGIT;
         end else if (close_value > MAX_BYTE_VALUE ||
                      (close_minus && close_value != 9'd0)) begin
            closed_error = ST_RANGE;
         end else if (count_ff < ADDRESS_NUMBERS) begin
            closed_addr  = addr_ff |
                           (32'(close_value[7:0]) << {count_ff[1:0], 3'b000});
            closed_count = count_ff + 3'd1;
         end else begin
            closed_port  = {port_ff[7:0], close_value[7:0]};
            closed_count = count_ff + 3'd1;
         end
      end
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      value_in = value_ff;
      minus_in = minus_ff;
      addr_in  = addr_ff;
      port_in  = port_ff;
      error_in = error_ff;
      if (byte_taken) begin
         if (last) begin
            phase_in = PH_BETWEEN;
            count_in = 3'd0;
            value_in = 9'd0;
            minus_in = 1'b0;
            addr_in  = 32'd0;
            port_in  = 16'd0;
            error_in = ST_OK;
         end else if (is_delim) begin
            phase_in = PH_BETWEEN;
            count_in = closed_count;
            value_in = 9'd0;
            minus_in = 1'b0;
            addr_in  = closed_addr;
            port_in  = closed_port;
            error_in = closed_error;
         end else begin
            phase_in = step_phase;
            value_in = step_value;
            minus_in = step_minus;
         end
      end
   end

   // Result outputs.
   always_comb begin
      if (closed_error != ST_OK) begin
         final_status = closed_error;
      end else if (closed_count < NUMBER_TOTAL) begin
         final_status = ST_FEW;
      end else begin
         final_status = ST_OK;
      end
      result_valid             = byte_taken && last;
      result_data.status       = final_status;
      result_data.address      = (final_status == ST_OK) ? closed_addr : 32'd0;
      result_data.port_number  = (final_status == ST_OK) ? closed_port : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIMITER_RESET;
         phase_ff     <= PH_BETWEEN;
         count_ff     <= 3'd0;
         value_ff     <= 9'd0;
         minus_ff     <= 1'b0;
         addr_ff      <= 32'd0;
         port_ff      <= 16'd0;
         error_ff     <= ST_OK;
      end else begin
         if (csr_write_enable) begin
            delimiter_ff <= csr_write_data;
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         value_ff <= value_in;
         minus_ff <= minus_in;
         addr_ff  <= addr_in;
         port_ff  <= port_in;
         error_ff <= error_in;
      end
   end

endmodule

// File: rtl/core/hpap_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpap_out_reg
// Result register presenting one parse result until it is taken.
// ----------------------------------------------------------------------------
module hpap_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  hpap_pkg::rsp_payload_type load_data,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hpap_pkg::rsp_payload_type rsp_payload
);
   import hpap_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;
   rsp_payload_type data_in;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// File: rtl/core/host_port_argument_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_port_argument_parser
// Byte-stream parser for the argument of an FTP PORT command.
// ----------------------------------------------------------------------------
// The block takes one argument byte per transaction and sustains one byte per
// clock cycle while no final byte waits for room. A byte enters an input
// register and is applied to the token state in the following cycle, and a
// byte flagged as the last one places a result in the output register. The
// output register lets parsing continue while a result waits;
// only a final byte is held back, in the input register, until the previous
// result has been taken. The argument holds six decimal numbers separated by
// the delimiter byte (a comma after reset, rewritable through the csr_ port
// while the block is idle). Runs of delimiters merge into one, leading
// delimiters are skipped, each number may open with whitespace and a sign,
// and text after the digits of a number is ignored. The result carries the
// first error found, or too few numbers; on success the address holds the
// first number in its low byte and the port is the fifth number times 256
// plus the sixth. After each result the parser returns to its initial state.
// ----------------------------------------------------------------------------
module host_port_argument_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hpap_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hpap_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_write_data
);
   import hpap_pkg::*;

   // Byte held in the input register and whether the parser takes it now.
   logic            hold_valid;
   req_payload_type hold_data;
   logic            byte_taken;

   // Result produced by the parser this cycle, and room to store it.
   logic            result_valid;
   rsp_payload_type result_data;
   logic            can_load;

   // The input register frees its slot whenever the parser consumes the byte,
   // so a fresh transaction may be accepted in the same cycle.
   hpap_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (byte_taken),
      .hold_valid  (hold_valid),
      .hold_data   (hold_data)
   );

   // The parser owns the delimiter register and all token state. It declines
   // a final byte only while the output register is occupied and not being
   // emptied in the same cycle.
   hpap_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .byte_valid       (hold_valid),
      .byte_data        (hold_data),
      .result_ready     (can_load),
      .byte_taken       (byte_taken),
      .result_valid     (result_valid),
      .result_data      (result_data)
   );

   // The output register keeps a result stable until the consumer takes it.
   hpap_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (result_valid),
      .load_data   (result_data),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/core/hpap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpap_checker
// Port-level checks for the PORT argument parser, bound to the top level.
// ----------------------------------------------------------------------------
module hpap_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input hpap_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input hpap_pkg::rsp_payload_type rsp_payload
);
   import hpap_pkg::*;

   // A pending result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // A failed parse never reports an address or a port.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |->
         rsp_payload.address == 32'd0 && rsp_payload.port_number == 16'd0)
      else $error("error result with non-zero address or port");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A result that appears in an empty output register comes from a final
   // byte accepted at the request port, held in the input register and then loaded into the output register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.last_byte, 2))
      else $error("result without a matching final byte");

endmodule

bind host_port_argument_parser hpap_checker u_hpap_checker (.*);
